@@ sv/assert_macros.svh @@
// Assertion macros included by the field checker RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst
`define CHK_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ssh_wfc_pkg.sv @@
// Types and constants of the SSH wire field checker
package ssh_wfc_pkg;

  localparam int unsigned LENGTH_BITS_DEFAULT = 32;
  localparam int unsigned VLEN_W = 32;
  localparam int unsigned TOTAL_W = 33;
  localparam int unsigned KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_STRING   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MPINT    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NAMELIST = 2'd2;

  localparam logic [1:0] HEADER_LAST = 2'd3;
  localparam logic [TOTAL_W-1:0] HEADER_BYTES = 33'd4;

  localparam logic [7:0] CHAR_COMMA = 8'h2c;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DEL   = 8'h7f;
  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] BYTE_ONES  = 8'hff;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_END  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PARSE   = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

endpackage

@@ sv/ssh_wire_field_checker.sv @@
// Top level of the SSH wire field checker
// Checks one SSH wire field (4-byte big-endian length, then that many value bytes)
// per result, in plain string, mpint or name-list mode as set by field_kind. A word
// is one buffer byte or an end-of-buffer mark; the block takes one word per cycle
// while item_stall is low. An accepted word waits in the input register while the
// byte check and counter update run, and its result loads into the result register
// when the word leaves the input register. A stalled result holds an input word
// that would produce a result, which then stalls the input. A result appears when
// a field completes, when the length exceeds LENGTH_BITS bits, or when an
// end-of-buffer mark cuts a field short. The user must write field_kind only while
// no word is in flight; the block itself does not enforce this.
module ssh_wire_field_checker #(
  parameter int unsigned LENGTH_BITS = ssh_wfc_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ssh_wfc_pkg::KIND_W-1:0]       cfg_data,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic                                 opcode,
  input  logic [7:0]                           data_byte,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output ssh_wfc_pkg::status_t                 status,
  output logic [ssh_wfc_pkg::TOTAL_W-1:0]      total_length,
  output logic [ssh_wfc_pkg::VLEN_W-1:0]       value_length
);
  import ssh_wfc_pkg::*;

  logic [KIND_W-1:0]      field_kind;

  logic                   s1_valid;
  op_t                    s1_opcode;
  logic [7:0]             s1_byte;
  logic                   s1_advance;
  logic                   out_free;

  logic                   in_body, in_body_next;
  logic [1:0]             header_count, header_count_next;
  logic [VLEN_W-1:0]      declared_length, declared_length_next;
  logic [LENGTH_BITS-1:0] body_count, body_count_next;
  logic [7:0]             previous_byte, previous_byte_next;
  status_t                content_fault, content_fault_next;

  logic                   produce;
  status_t                res_status;
  logic [TOTAL_W-1:0]     res_total;
  logic [VLEN_W-1:0]      res_vlen;
  logic [VLEN_W-1:0]      decl_shift;
  logic [LENGTH_BITS-1:0] body_inc;
  logic                   last_byte;
  status_t                byte_fault;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_kind <= KIND_STRING;
    end else if (cfg_valid && cfg_ready) begin
      field_kind <= cfg_data;
    end
  end

  assign out_free   = !result_valid || !result_stall;
  assign s1_advance = s1_valid && (!produce || out_free);
  assign item_stall = s1_valid && !s1_advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_opcode <= op_t'(opcode);
      s1_byte   <= data_byte;
    end
  end

  assign decl_shift = {declared_length[VLEN_W-9:0], s1_byte};
  assign body_inc   = body_count + 1'b1;
  assign last_byte  = body_inc == declared_length[LENGTH_BITS-1:0];

  // Content check of one value byte
  always_comb begin
    byte_fault = ST_OK;
    case (field_kind)
      KIND_MPINT: begin
        if (body_count == LENGTH_BITS'(1)) begin
          if ((previous_byte == BYTE_ZERO && !s1_byte[7]) ||
              (previous_byte == BYTE_ONES && s1_byte[7])) begin
            byte_fault = ST_INVALID;
          end
        end
      end
      KIND_NAMELIST: begin
        if ((s1_byte == CHAR_COMMA &&
             (body_count == '0 || previous_byte == CHAR_COMMA)) ||
            s1_byte <= CHAR_SPACE || s1_byte >= CHAR_DEL ||
            (last_byte && s1_byte == CHAR_COMMA)) begin
          byte_fault = ST_PARSE;
        end
      end
      default: byte_fault = ST_OK;
    endcase
  end

  // Field state update and result
  always_comb begin
    in_body_next         = in_body;
    header_count_next    = header_count;
    declared_length_next = declared_length;
    body_count_next      = body_count;
    previous_byte_next   = previous_byte;
    content_fault_next   = content_fault;
    produce              = 1'b0;
    res_status           = ST_OK;
    res_total            = '0;
    res_vlen             = '0;

    if (s1_opcode == OP_END) begin
      if (in_body) begin
        produce    = 1'b1;
        res_status = ST_PARSE;
        res_vlen   = declared_length;
      end else if (header_count != 2'd0) begin
        produce    = 1'b1;
        res_status = ST_PARSE;
      end
    end else if (!in_body) begin
      declared_length_next = decl_shift;
      if (header_count == HEADER_LAST) begin
        header_count_next = 2'd0;
        if ((decl_shift >> LENGTH_BITS) != '0) begin
          produce    = 1'b1;
          res_status = ST_INVALID;
          res_vlen   = decl_shift;
        end else if (decl_shift == '0) begin
          produce    = 1'b1;
          res_status = ST_OK;
          res_total  = HEADER_BYTES;
        end else begin
          in_body_next       = 1'b1;
          body_count_next    = '0;
          previous_byte_next = '0;
          content_fault_next = ST_OK;
        end
      end else begin
        header_count_next = header_count + 2'd1;
      end
    end else begin
      content_fault_next = (content_fault == ST_OK) ? byte_fault : content_fault;
      previous_byte_next = s1_byte;
      body_count_next    = body_inc;
      if (last_byte) begin
        produce    = 1'b1;
        res_status = content_fault_next;
        res_vlen   = declared_length;
        if (content_fault_next == ST_OK) begin
          res_total = {1'b0, declared_length} + HEADER_BYTES;
        end
      end
    end

    // Clear the field once it reports
    if (produce) begin
      in_body_next         = 1'b0;
      header_count_next    = 2'd0;
      declared_length_next = '0;
      body_count_next      = '0;
      previous_byte_next   = '0;
      content_fault_next   = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_body         <= 1'b0;
      header_count    <= 2'd0;
      declared_length <= '0;
      body_count      <= '0;
      previous_byte   <= '0;
      content_fault   <= ST_OK;
    end else if (s1_advance) begin
      in_body         <= in_body_next;
      header_count    <= header_count_next;
      declared_length <= declared_length_next;
      body_count      <= body_count_next;
      previous_byte   <= previous_byte_next;
      content_fault   <= content_fault_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_advance && produce) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && produce) begin
      status       <= res_status;
      total_length <= res_total;
      value_length <= res_vlen;
    end
  end

  `include "assert_macros.svh"

  `CHK_IMPLIES(a_body_no_header, in_body, header_count == 2'd0, "header count left in body")
  `CHK_IMPLIES(a_body_in_range, in_body,
    body_count < declared_length[LENGTH_BITS-1:0], "body count past declared length")
  `CHK_IMPLIES(a_fail_no_total, result_valid && status != ST_OK,
    total_length == '0, "total length on failed field")
  `CHK_IMPLIES(a_ok_total, result_valid && status == ST_OK,
    total_length == {1'b0, value_length} + HEADER_BYTES, "total length mismatch")
  `CHK_NEXT(a_result_cleared, s1_advance && produce, !in_body && header_count == 2'd0,
    "field state not cleared after result")

endmodule

@@ tb/sv/tb_ssh_wire_field_checker.sv @@
// Testbench for ssh_wire_field_checker: directed and random fields against a local predictor
module tb_ssh_wire_field_checker;
  import ssh_wfc_pkg::*;

  localparam int unsigned LEN_BITS = LENGTH_BITS_DEFAULT;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_WORDS = 100;

  typedef struct {
    status_t status;
    logic [TOTAL_W-1:0] total;
    logic [VLEN_W-1:0] vlen;
  } field_result_t;

  class field_scoreboard;
    logic [KIND_W-1:0] kind;
    bit in_body;
    logic [1:0] hdr_cnt;
    logic [VLEN_W-1:0] decl_len;
    logic [VLEN_W-1:0] body_cnt;
    logic [7:0] prev_byte;
    status_t fault;
    field_result_t pending_results[$];
    int errors;

    function new();
      kind = KIND_STRING;
      errors = 0;
      clear_field();
    endfunction

    function void clear_field();
      in_body = 1'b0;
      hdr_cnt = '0;
      decl_len = '0;
      body_cnt = '0;
      prev_byte = '0;
      fault = ST_OK;
    endfunction

    function void push_result(status_t st, logic [TOTAL_W-1:0] total,
                              logic [VLEN_W-1:0] vlen);
      field_result_t r;
      r.status = st;
      r.total = total;
      r.vlen = vlen;
      pending_results.push_back(r);
      clear_field();
    endfunction

    function status_t byte_fault(logic [7:0] b, bit last);
      if (kind == KIND_MPINT) begin
        if (body_cnt == 1 && ((prev_byte == BYTE_ZERO && !b[7]) ||
                              (prev_byte == BYTE_ONES && b[7])))
          return ST_INVALID;
      end else if (kind == KIND_NAMELIST) begin
        if (b == CHAR_COMMA && (body_cnt == 0 || prev_byte == CHAR_COMMA))
          return ST_PARSE;
        if (b <= CHAR_SPACE || b >= CHAR_DEL)
          return ST_PARSE;
        if (last && b == CHAR_COMMA)
          return ST_PARSE;
      end
      return ST_OK;
    endfunction

    function void note_word(op_t op, logic [7:0] b);
      status_t f;
      bit last;
      if (op == OP_END) begin
        if (in_body)
          push_result(ST_PARSE, '0, decl_len);
        else if (hdr_cnt != 0)
          push_result(ST_PARSE, '0, '0);
        return;
      end
      if (!in_body) begin
        decl_len = {decl_len[VLEN_W-9:0], b};
        if (hdr_cnt != HEADER_LAST) begin
          hdr_cnt++;
          return;
        end
        hdr_cnt = '0;
        if ((64'(decl_len) >> LEN_BITS) != 0)
          push_result(ST_INVALID, '0, decl_len);
        else if (decl_len == 0)
          push_result(ST_OK, HEADER_BYTES, '0);
        else begin
          in_body = 1'b1;
          body_cnt = '0;
          prev_byte = '0;
          fault = ST_OK;
        end
        return;
      end
      last = (body_cnt + 1) == decl_len;
      f = byte_fault(b, last);
      if (fault == ST_OK)
        fault = f;
      prev_byte = b;
      body_cnt++;
      if (body_cnt == decl_len) begin
        if (fault != ST_OK)
          push_result(fault, '0, decl_len);
        else
          push_result(ST_OK, {1'b0, decl_len} + HEADER_BYTES, decl_len);
      end
    endfunction

    function void check_result(status_t st, logic [TOTAL_W-1:0] total,
                               logic [VLEN_W-1:0] vlen);
      field_result_t w;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d, total_length %0d, value_length %0d",
               st, total, vlen);
        errors++;
        return;
      end
      w = pending_results.pop_front();
      if (st !== w.status) begin
        $error("status: expected %0d, got %0d", w.status, st);
        errors++;
      end
      if (total !== w.total) begin
        $error("total_length: expected %0d, got %0d", w.total, total);
        errors++;
      end
      if (vlen !== w.vlen) begin
        $error("value_length: expected %0d, got %0d", w.vlen, vlen);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [KIND_W-1:0] cfg_data = KIND_STRING;
  logic item_valid = 1'b0;
  logic item_stall;
  logic opcode = OP_BYTE;
  logic [7:0] data_byte = 8'h00;
  logic result_valid;
  logic result_stall = 1'b0;
  status_t status;
  logic [TOTAL_W-1:0] total_length;
  logic [VLEN_W-1:0] value_length;

  field_scoreboard sb = new();
  int send_idle = 28;
  int recv_idle = 84;
  int words_sent = 0;
  int cycle_count = 0;
  logic [KIND_W-1:0] kind_order [4];

  ssh_wire_field_checker #(
    .LENGTH_BITS(LEN_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .opcode(opcode),
    .data_byte(data_byte),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .status(status),
    .total_length(total_length),
    .value_length(value_length)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk) begin
    result_stall <= ($urandom_range(0, 99) < recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_result(status, total_length, value_length);
  end

  task automatic send_word(op_t op, logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    opcode <= op;
    data_byte <= b;
    do @(posedge clk); while (item_stall);
    sb.note_word(op, b);
    words_sent++;
  endtask

  task automatic send_header(logic [31:0] len);
    for (int i = 3; i >= 0; i--)
      send_word(OP_BYTE, len[8*i +: 8]);
  endtask

  task automatic settle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (sb.pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_kind(logic [KIND_W-1:0] k);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= k;
    do @(posedge clk); while (!cfg_ready);
    sb.kind = k;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic rand_field();
    logic [31:0] len;
    longint cut;
    bit prev_comma;
    logic [7:0] b;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      send_word(OP_END, 8'($urandom));
      return;
    end
    if (sel < 18)
      len = $urandom;
    else if (sel < 30)
      len = $urandom_range(13, 40);
    else
      len = $urandom_range(0, 12);
    cut = -1;
    if (sel < 18)
      cut = $urandom_range(0, 9);
    else if ($urandom_range(0, 99) < 8)
      cut = $urandom_range(0, len + 3);
    if (cut >= 0 && cut < 4) begin
      for (int i = 0; i < cut; i++)
        send_word(OP_BYTE, len[8*(3-i) +: 8]);
      send_word(OP_END, 8'($urandom));
      return;
    end
    send_header(len);
    prev_comma = 1'b0;
    for (longint i = 0; i < longint'(len); i++) begin
      if (cut >= 0 && i == cut - 4) begin
        send_word(OP_END, 8'($urandom));
        return;
      end
      case (sb.kind)
        KIND_MPINT: begin
          if (i == 0 && $urandom_range(0, 1))
            b = $urandom_range(0, 1) ? BYTE_ZERO : BYTE_ONES;
          else
            b = 8'($urandom);
        end
        KIND_NAMELIST: begin
          if ($urandom_range(0, 99) < 4)
            b = 8'($urandom);
          else if (i != 0 && i != longint'(len) - 1 && !prev_comma &&
                   $urandom_range(0, 3) == 0)
            b = CHAR_COMMA;
          else begin
            b = 8'($urandom_range(8'h21, 8'h7e));
            if (b == CHAR_COMMA)
              b = 8'h2d;
          end
          prev_comma = (b == CHAR_COMMA);
        end
        default: b = 8'($urandom);
      endcase
      send_word(OP_BYTE, b);
    end
  endtask

  initial begin
    int target;
    kind_order = '{KIND_SPARE, KIND_MPINT, KIND_NAMELIST, KIND_STRING};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_kind(KIND_STRING);
    send_header(32'h0000_0000);
    send_word(OP_END, 8'hff);
    send_header(32'hffff_ffff);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_END, 8'h00);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_END, 8'h00);
    write_kind(KIND_MPINT);
    send_header(32'd3);
    send_word(OP_BYTE, BYTE_ZERO);
    send_word(OP_BYTE, 8'h7f);
    send_word(OP_END, 8'h00);
    write_kind(KIND_NAMELIST);
    send_header(32'd2);
    send_word(OP_BYTE, CHAR_COMMA);
    send_word(OP_BYTE, 8'h7e);

    for (int p = 0; p < 3; p++) begin
      send_idle = (p == 0) ? 28 : (p == 1) ? 84 : 0;
      recv_idle = (p == 0) ? 84 : (p == 1) ? 28 : 0;
      for (int k = 0; k < 4; k++) begin
        write_kind(kind_order[(k + p) % 4]);
        target = words_sent + PHASE_WORDS;
        while (words_sent < target)
          rand_field();
        // leave a field open across the next kind change
        if ($urandom_range(0, 1)) begin
          send_header({24'h0, 8'($urandom_range(2, 6))});
          send_word(OP_BYTE, 8'($urandom));
        end
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
